// ----- rtl/lsps_pkg.sv -----
// ----------------------------------------------------------------------------
// lsps_pkg
// Shared types and constants of the line-sensor steering unit.
// ----------------------------------------------------------------------------
package lsps_pkg;

    localparam int SensorCount = 8;
    localparam int SampleWidth = 10;
    localparam int GainWidth   = 12;
    localparam int LevelWidth  = 8;
    localparam int CfgAddrWidth = 3;
    localparam int CfgDataWidth = 12;

    localparam logic [CfgAddrWidth-1:0] REG_TH_FIRST  = 3'd0;
    localparam logic [CfgAddrWidth-1:0] REG_TH_MIDDLE = 3'd1;
    localparam logic [CfgAddrWidth-1:0] REG_TH_LAST   = 3'd2;
    localparam logic [CfgAddrWidth-1:0] REG_GAIN_P    = 3'd3;
    localparam logic [CfgAddrWidth-1:0] REG_GAIN_I    = 3'd4;
    localparam logic [CfgAddrWidth-1:0] REG_GAIN_D    = 3'd5;
    localparam logic [CfgAddrWidth-1:0] REG_TOP_SPEED = 3'd6;

    localparam logic [1:0] MODE_FORWARD = 2'd0;
    localparam logic [1:0] MODE_LEFT    = 2'd1;
    localparam logic [1:0] MODE_RIGHT   = 2'd2;

    localparam logic [1:0] CORNER_NONE  = 2'd0;
    localparam logic [1:0] CORNER_RIGHT = 2'd1;
    localparam logic [1:0] CORNER_ACUTE = 2'd2;

    localparam logic [7:0] RUN_ACUTE_LO = 8'd15;
    localparam logic [7:0] RUN_ACUTE_HI = 8'd100;
    localparam logic [7:0] RUN_MAX      = 8'hFF;

    typedef struct packed {
        logic [SampleWidth-1:0] sample_0;
        logic [SampleWidth-1:0] sample_1;
        logic [SampleWidth-1:0] sample_2;
        logic [SampleWidth-1:0] sample_3;
        logic [SampleWidth-1:0] sample_4;
        logic [SampleWidth-1:0] sample_5;
        logic [SampleWidth-1:0] sample_6;
        logic [SampleWidth-1:0] sample_7;
    } frame_t;

    typedef struct packed {
        logic [7:0]        left_drive;
        logic [7:0]        right_drive;
        logic [1:0]        turn_mode;
        logic [1:0]        corner_kind;
        logic [7:0]        line_pattern;
        logic signed [7:0] line_position;
        logic              all_line;
        logic              acute_latched;
    } result_t;

    // Classified frame handed from front to back.
    typedef struct packed {
        logic [7:0]        pattern;
        logic              no_line;
        logic              all_line;
        logic [1:0]        corner;
        logic signed [8:0] sum;
        logic [4:0]        count;
    } task_t;

endpackage

// ----- rtl/line_sensor_pid_steering_unit.sv -----
// ----------------------------------------------------------------------------
// line_sensor_pid_steering_unit
// Line-sensor centroid position and PID wheel steering.
// ----------------------------------------------------------------------------
// A frame with a partial line passes, from push to result, through the front
// classifier and queue, the load of the back unit, the bit-serial position
// divider, a multiply, a sum, an output step and the write of the result
// queue. A frame with no line skips the divider; an all-line frame also skips
// the PID. The back unit handles one frame at a time and starts the next only
// once the result queue is empty; a two-entry queue sits between front and
// back and a two-entry result queue sits at the output.
module line_sensor_pid_steering_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  lsps_pkg::frame_t                      in_word,
    output logic                                  empty,
    input  logic                                  pop,
    output lsps_pkg::result_t                     out_word,
    input  logic                                  cfg_we,
    input  logic [lsps_pkg::CfgAddrWidth-1:0]     cfg_index,
    input  logic [lsps_pkg::CfgDataWidth-1:0]     cfg_data
);
    logic [9:0]  th_first_reg, th_middle_reg, th_last_reg;
    logic [11:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [7:0]  top_reg;

    lsps_pkg::task_t   job;
    lsps_pkg::task_t   q_reg [2];
    logic [1:0]        q_cnt_reg;
    logic              q_rd_reg, q_wr_reg;
    lsps_pkg::result_t r_reg [2];
    logic [1:0]        r_cnt_reg;
    logic              r_rd_reg, r_wr_reg;
    logic              busy, done, start;
    lsps_pkg::result_t res;
    logic              in_go, out_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_first_reg  <= 10'd550;
            th_middle_reg <= 10'd600;
            th_last_reg   <= 10'd450;
            gain_p_reg    <= 12'd80;
            gain_i_reg    <= 12'd0;
            gain_d_reg    <= 12'd272;
            top_reg       <= 8'd200;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsps_pkg::REG_TH_FIRST:  th_first_reg  <= cfg_data[9:0];
                lsps_pkg::REG_TH_MIDDLE: th_middle_reg <= cfg_data[9:0];
                lsps_pkg::REG_TH_LAST:   th_last_reg   <= cfg_data[9:0];
                lsps_pkg::REG_GAIN_P:    gain_p_reg    <= cfg_data;
                lsps_pkg::REG_GAIN_I:    gain_i_reg    <= cfg_data;
                lsps_pkg::REG_GAIN_D:    gain_d_reg    <= cfg_data;
                lsps_pkg::REG_TOP_SPEED: top_reg       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    lsps_front u_front (
        .samples   (in_word),
        .th_first  (th_first_reg),
        .th_middle (th_middle_reg),
        .th_last   (th_last_reg),
        .job       (job)
    );

    // hold back input while results could overflow the output queue
    assign full   = (q_cnt_reg == 2'd2) || (r_cnt_reg != 2'd0 && q_cnt_reg != 2'd0);
    assign in_go  = push && !full;
    assign start  = !busy && q_cnt_reg != 2'd0 && r_cnt_reg == 2'd0;
    assign empty  = r_cnt_reg == 2'd0;
    assign out_go = pop && !empty;
    assign out_word = r_reg[r_rd_reg];

    always_ff @(posedge clk)
    begin
        if (in_go)
            q_reg[q_wr_reg] <= job;
        if (done)
            r_reg[r_wr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
            q_rd_reg  <= 1'b0;
            q_wr_reg  <= 1'b0;
            r_cnt_reg <= '0;
            r_rd_reg  <= 1'b0;
            r_wr_reg  <= 1'b0;
        end
        else
        begin
            if (in_go)
                q_wr_reg <= !q_wr_reg;
            if (start)
                q_rd_reg <= !q_rd_reg;
            q_cnt_reg <= q_cnt_reg + 2'(in_go) - 2'(start);
            if (done)
                r_wr_reg <= !r_wr_reg;
            if (out_go)
                r_rd_reg <= !r_rd_reg;
            r_cnt_reg <= r_cnt_reg + 2'(done) - 2'(out_go);
        end
    end

    lsps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .job       (q_reg[q_rd_reg]),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .top_speed (top_reg),
        .busy      (busy),
        .done      (done),
        .res       (res)
    );
endmodule

// ----- rtl/lsps_front.sv -----
// ----------------------------------------------------------------------------
// lsps_front
// Thresholds a frame and forms pattern, weight sum, count and corner kind.
// ----------------------------------------------------------------------------
module lsps_front (
    input  logic [lsps_pkg::SensorCount*lsps_pkg::SampleWidth-1:0] samples,
    input  logic [lsps_pkg::SampleWidth-1:0]              th_first,
    input  logic [lsps_pkg::SampleWidth-1:0]              th_middle,
    input  logic [lsps_pkg::SampleWidth-1:0]              th_last,
    output lsps_pkg::task_t                               job
);
    localparam int IdxW = $clog2(lsps_pkg::SensorCount);

    logic [lsps_pkg::SensorCount-1:0] hit;
    logic signed [11:0]      sum;
    logic [IdxW:0]           cnt;
    logic [IdxW-1:0]         lo;
    logic [IdxW-1:0]         hi;
    logic                    any;
    logic [IdxW:0]           span;
    logic signed [IdxW+1:0]  gaps;
    logic [lsps_pkg::SampleWidth-1:0] th;

    always_comb
    begin
        sum = '0;
        cnt = '0;
        lo  = '0;
        hi  = '0;
        any = 1'b0;
        th  = th_middle;
        for (int i = 0; i < lsps_pkg::SensorCount; i++)
        begin
            if (i == 0)
                th = th_first;
            else if (i == lsps_pkg::SensorCount - 1)
                th = th_last;
            else
                th = th_middle;
            hit[i] = samples[(lsps_pkg::SensorCount-1-i)*lsps_pkg::SampleWidth +:
                             lsps_pkg::SampleWidth] <= th;
            if (hit[i])
            begin
                sum = sum + 12'(signed'((2 * i - (lsps_pkg::SensorCount - 1)) * 10));
                cnt = cnt + 1'b1;
                if (!any)
                    lo = IdxW'(i);
                hi  = IdxW'(i);
                any = 1'b1;
            end
        end
        span = (IdxW+1)'(hi) - (IdxW+1)'(lo);
        gaps = signed'((IdxW+2)'(span) + 1'b1) - signed'((IdxW+2)'(cnt));
        job.corner = lsps_pkg::CORNER_NONE;
        // span of three to five sensor steps
        if (span >= 3 && span <= 5)
        begin
            if (gaps == 0)
                job.corner = lsps_pkg::CORNER_RIGHT;
            else if (gaps >= 1 && gaps < 4)
                job.corner = lsps_pkg::CORNER_ACUTE;
        end
        for (int i = 0; i < 8; i++)
            job.pattern[i] = (i < lsps_pkg::SensorCount) ?
                             hit[lsps_pkg::SensorCount-1-i] : 1'b0;
        job.no_line  = !any;
        job.all_line = &hit;
        job.sum      = 9'(sum);
        job.count    = 5'(cnt);
    end
endmodule

// ----- rtl/lsps_back.sv -----
// ----------------------------------------------------------------------------
// lsps_back
// Divides the weight sum, runs the PID and holds the drive state.
// ----------------------------------------------------------------------------
module lsps_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  lsps_pkg::task_t                     job,
    input  logic [lsps_pkg::GainWidth-1:0]      gain_p,
    input  logic [lsps_pkg::GainWidth-1:0]      gain_i,
    input  logic [lsps_pkg::GainWidth-1:0]      gain_d,
    input  logic [lsps_pkg::LevelWidth-1:0]     top_speed,
    output logic                                busy,
    output logic                                done,
    output lsps_pkg::result_t                   res
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    lsps_pkg::task_t   job_reg;
    logic [2:0]        step_reg;
    logic [6:0]        quo_reg;
    logic [7:0]        rem_reg;
    logic signed [7:0] pos_reg;
    logic signed [7:0] held_reg, last_err_reg, avg_reg;
    logic [7:0]        run_reg;
    logic              acute_reg;
    logic [7:0]        left_reg, right_reg;
    logic [1:0]        mode_reg;
    logic signed [22:0] tp_reg, ti_reg, td_reg;
    logic signed [24:0] acc_reg;

    logic [7:0]        mag;
    logic [7:0]        trial;
    logic signed [8:0] err, newavg_w, diff;
    logic signed [24:0] acc_sum;
    logic signed [20:0] resp;
    logic signed [20:0] m;
    logic signed [20:0] rev_left;
    logic signed [20:0] rev_right;

    assign mag = job_reg.sum[8] ? 8'(-job_reg.sum) : 8'(job_reg.sum);
    assign trial = {rem_reg[6:0], mag[3'(step_reg)]};
    assign err  = -9'(pos_reg);
    assign newavg_w = 9'((10'(avg_reg) + 10'(err)) / 2);
    assign diff = 9'(err - 9'(last_err_reg));
    assign acc_sum = 25'(tp_reg) + 25'(ti_reg) + 25'(td_reg);
    assign resp = 21'(acc_reg / 16);
    assign m = 21'(top_speed);
    assign rev_left  = resp - m;
    assign rev_right = -resp - m;
    assign busy = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_DIV;
            S_DIV:  if (job_reg.no_line || job_reg.all_line || step_reg == 3'd0)
                        state_next = job_reg.all_line ? S_OUT : S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            last_err_reg <= '0;
            avg_reg      <= '0;
            run_reg      <= '0;
            acute_reg    <= 1'b0;
            left_reg     <= '0;
            right_reg    <= '0;
            mode_reg     <= lsps_pkg::MODE_FORWARD;
            done         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    job_reg  <= job;
                    step_reg <= 3'd7;
                    quo_reg  <= '0;
                    rem_reg  <= '0;
                end
                S_DIV:
                begin
                    // restoring divide, one quotient bit a cycle
                    if (trial >= 8'(job_reg.count))
                    begin
                        rem_reg <= trial - 8'(job_reg.count);
                        quo_reg <= {quo_reg[5:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[5:0], 1'b0};
                    end
                    step_reg <= step_reg - 1'b1;
                    if (job_reg.no_line)
                    begin
                        pos_reg <= held_reg;
                        if (run_reg > lsps_pkg::RUN_ACUTE_LO &&
                            run_reg < lsps_pkg::RUN_ACUTE_HI)
                            acute_reg <= 1'b1;
                        run_reg <= '0;
                    end
                    else if (job_reg.all_line)
                    begin
                        pos_reg <= '0;
                        if (run_reg != lsps_pkg::RUN_MAX)
                            run_reg <= run_reg + 1'b1;
                        mode_reg  <= lsps_pkg::MODE_FORWARD;
                        left_reg  <= top_speed;
                        right_reg <= top_speed;
                    end
                    else if (step_reg == 3'd0)
                    begin
                        run_reg <= '0;
                        if (trial >= 8'(job_reg.count))
                        begin
                            pos_reg <= job_reg.sum[8] ? -8'({quo_reg[6:0], 1'b1} & 8'h7F)
                                                      : 8'({quo_reg[6:0], 1'b1} & 8'h7F);
                            held_reg <= job_reg.sum[8] ? -8'({quo_reg[6:0], 1'b1} & 8'h7F)
                                                       : 8'({quo_reg[6:0], 1'b1} & 8'h7F);
                        end
                        else
                        begin
                            pos_reg <= job_reg.sum[8] ? -8'({quo_reg[6:0], 1'b0} & 8'h7F)
                                                      : 8'({quo_reg[6:0], 1'b0} & 8'h7F);
                            held_reg <= job_reg.sum[8] ? -8'({quo_reg[6:0], 1'b0} & 8'h7F)
                                                       : 8'({quo_reg[6:0], 1'b0} & 8'h7F);
                        end
                    end
                end
                S_MUL:
                begin
                    tp_reg  <= 23'(signed'({1'b0, gain_p}) * err);
                    ti_reg  <= 23'(signed'({1'b0, gain_i}) * newavg_w);
                    td_reg  <= 23'(signed'({1'b0, gain_d}) * diff);
                    avg_reg      <= 8'(newavg_w);
                    last_err_reg <= 8'(err);
                end
                S_SUM:
                    acc_reg <= acc_sum;
                S_OUT:
                begin
                    done <= 1'b1;
                    if (!job_reg.all_line)
                    begin
                        if (resp > m)
                        begin
                            mode_reg  <= lsps_pkg::MODE_LEFT;
                            left_reg  <= (rev_left > m) ? top_speed : 8'(rev_left);
                            right_reg <= top_speed;
                        end
                        else if (resp < -m)
                        begin
                            mode_reg  <= lsps_pkg::MODE_RIGHT;
                            left_reg  <= top_speed;
                            right_reg <= (rev_right > m) ? top_speed : 8'(rev_right);
                        end
                        else if (resp < 0 && resp > -m)
                        begin
                            mode_reg  <= lsps_pkg::MODE_FORWARD;
                            left_reg  <= top_speed;
                            right_reg <= 8'(m + resp);
                        end
                        else if (resp > 0 && resp < m)
                        begin
                            mode_reg  <= lsps_pkg::MODE_FORWARD;
                            left_reg  <= 8'(m - resp);
                            right_reg <= top_speed;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res.left_drive    = left_reg;
        res.right_drive   = right_reg;
        res.turn_mode     = mode_reg;
        res.corner_kind   = (job_reg.no_line || job_reg.all_line) ?
                            lsps_pkg::CORNER_NONE : job_reg.corner;
        res.line_pattern  = job_reg.pattern;
        res.line_position = pos_reg;
        res.all_line      = job_reg.all_line;
        res.acute_latched = acute_reg;
    end
endmodule
